// File: design/btm_pkg.sv
// Shared types and codes for the bracket tape machine core.
`timescale 1ns / 1ps

package btm_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_mode;
    typedef logic [2:0] t_err;
    typedef logic [1:0] t_status;

    // command characters
    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_OPEN  = 8'h5B;
    localparam t_byte CH_CLOSE = 8'h5D;
    localparam t_byte CH_LEFT  = 8'h3C;
    localparam t_byte CH_RIGHT = 8'h3E;
    localparam t_byte CH_PLUS  = 8'h2B;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_DOT   = 8'h2E;

    localparam t_mode MODE_READY   = 2'd0;
    localparam t_mode MODE_ENDED   = 2'd1;
    localparam t_mode MODE_ERROR   = 2'd2;
    localparam t_mode MODE_LOADING = 2'd3;

    localparam t_err ERR_NONE      = 3'd0;
    localparam t_err ERR_NEST_OVF  = 3'd1;
    localparam t_err ERR_PAIR_OVF  = 3'd2;
    localparam t_err ERR_STRAY     = 3'd3;
    localparam t_err ERR_OPEN_LEFT = 3'd4;
    localparam t_err ERR_TOO_LONG  = 3'd5;
    localparam t_err ERR_PTR_UNDER = 3'd6;
    localparam t_err ERR_PTR_OVER  = 3'd7;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_ENDED = 2'd1;
    localparam t_status ST_ERROR = 2'd2;

endpackage

// File: design/btm_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps

module btm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: design/bracket_tape_machine_core.sv
// Top level of the bracket tape machine: load scanner, command sequencer and memories.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// command   in         start & !busy              i_req_type i_prog_byte i_last_byte
//                                                 i_in_char i_in_eof
// result    out        o_result_strobe (1 cycle)  o_out_valid o_out_char o_in_taken
//                                                 o_run_status o_error_code o_next_pc
//
// A ']' that closes a pair adds the two match-table writes in S_PAIR_A and S_PAIR_B
// (one write port on that table). The beat carrying last_byte is followed by a clear
// of every data tape cell in S_CLEAR. An execute beat that runs a command reads the
// program, match and data memories on acceptance, then writes the cell in S_EXEC; one
// that finds the machine loading, ended or stopped finishes on acceptance.
// The result strobe is registered: it is high in the cycle after the accepting edge
// for a load or an execute that runs no command, and is registered from S_EXEC for one
// that runs a command; the receiver cannot stall. busy is high while an item is in
// flight. Reset is synchronous; no tape clear is needed after reset.
module bracket_tape_machine_core #(
    parameter int PROGRAM_DEPTH = 4096,
    parameter int DATA_DEPTH    = 4096,
    parameter int MAX_PAIRS     = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_req_type,
    input  logic [7:0]                          i_prog_byte,
    input  logic                                i_last_byte,
    input  logic [7:0]                          i_in_char,
    input  logic                                i_in_eof,
    output logic                                o_result_strobe,
    output logic                                o_out_valid,
    output logic [7:0]                          o_out_char,
    output logic                                o_in_taken,
    output logic [1:0]                          o_run_status,
    output logic [2:0]                          o_error_code,
    output logic [$clog2(PROGRAM_DEPTH+1)-1:0] o_next_pc
);

    localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
    localparam int PAW = $clog2(PROGRAM_DEPTH);
    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int SDW = $clog2(MAX_PAIRS + 1);
    localparam int SAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_PAIR_A = 3'd2;
    localparam logic [2:0] S_PAIR_B = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;

    logic [2:0]            r_state, n_state;
    btm_pkg::t_mode        r_mode, n_mode;
    btm_pkg::t_err         r_err, n_err;
    logic [PCW-1:0]        r_pc, n_pc;
    logic [DAW-1:0]        r_dp, n_dp;
    logic [PCW-1:0]        r_load_pos, n_load_pos;
    logic [SDW-1:0]        r_depth, n_depth;
    logic [SDW-1:0]        r_pairs, n_pairs;
    logic                  r_zero_seen, n_zero_seen;
    logic [PAW-1:0]        r_pair_pos, n_pair_pos;
    logic                  r_last, n_last;
    logic [DAW-1:0]        r_clr, n_clr;
    logic [7:0]            r_in_char, n_in_char;
    logic                  r_in_eof, n_in_eof;

    logic                  r_strobe, n_strobe;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_char, n_out_char;
    logic                  r_in_taken, n_in_taken;
    btm_pkg::t_status      r_status, n_status;
    btm_pkg::t_err         r_code, n_code;

    // memory ports
    logic                  prog_we, prog_re;
    logic [PAW-1:0]        prog_waddr, prog_raddr;
    logic [7:0]            prog_wdata, prog_rdata;
    logic                  jmp_we, jmp_re;
    logic [PAW-1:0]        jmp_waddr, jmp_raddr;
    logic [PAW-1:0]        jmp_wdata, jmp_rdata;
    logic                  stk_we, stk_re;
    logic [SAW-1:0]        stk_waddr, stk_raddr;
    logic [PAW-1:0]        stk_wdata, stk_rdata;
    logic                  dat_we, dat_re;
    logic [DAW-1:0]        dat_waddr, dat_raddr;
    logic [7:0]            dat_wdata, dat_rdata;

    logic                  accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        logic [PCW-1:0] lpos;
        logic [SDW-1:0] ldepth;
        logic [SDW-1:0] lpairs;
        logic [SDW-1:0] ldec;
        logic           lzero;
        btm_pkg::t_err  lerr;
        logic           lpair;

        n_state     = r_state;
        n_mode      = r_mode;
        n_err       = r_err;
        n_pc        = r_pc;
        n_dp        = r_dp;
        n_load_pos  = r_load_pos;
        n_depth     = r_depth;
        n_pairs     = r_pairs;
        n_zero_seen = r_zero_seen;
        n_pair_pos  = r_pair_pos;
        n_last      = r_last;
        n_clr       = r_clr;
        n_in_char   = r_in_char;
        n_in_eof    = r_in_eof;

        n_strobe    = 1'b0;
        n_out_valid = 1'b0;
        n_out_char  = 8'h00;
        n_in_taken  = 1'b0;
        n_status    = btm_pkg::ST_OK;
        n_code      = btm_pkg::ERR_NONE;

        prog_we    = 1'b0;
        prog_waddr = r_load_pos[PAW-1:0];
        prog_wdata = i_prog_byte;
        prog_re    = 1'b0;
        prog_raddr = r_pc[PAW-1:0];
        jmp_we     = 1'b0;
        jmp_waddr  = r_pair_pos;
        jmp_wdata  = stk_rdata;
        jmp_re     = 1'b0;
        jmp_raddr  = r_pc[PAW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_depth[SAW-1:0];
        stk_wdata  = r_load_pos[PAW-1:0];
        stk_re     = 1'b0;
        stk_raddr  = r_depth[SAW-1:0];
        dat_we     = 1'b0;
        dat_waddr  = r_dp;
        dat_wdata  = 8'h00;
        dat_re     = 1'b0;
        dat_raddr  = r_dp;

        lpos   = r_load_pos;
        ldepth = r_depth;
        lpairs = r_pairs;
        ldec   = r_depth - SDW'(1);
        lzero  = r_zero_seen;
        lerr   = r_err;
        lpair  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start && !i_req_type) begin
                    // a load beat outside a load opens a new program
                    if (r_mode != btm_pkg::MODE_LOADING) begin
                        lpos   = '0;
                        ldepth = '0;
                        lpairs = '0;
                        lzero  = 1'b0;
                        lerr   = btm_pkg::ERR_NONE;
                    end
                    ldec = ldepth - SDW'(1);
                    n_load_pos = lpos;
                    if (lpos >= PCW'(PROGRAM_DEPTH)) begin
                        lerr = btm_pkg::ERR_TOO_LONG;
                    end else begin
                        prog_we    = 1'b1;
                        prog_waddr = lpos[PAW-1:0];
                        n_load_pos = lpos + PCW'(1);
                        if (!lzero && lerr == btm_pkg::ERR_NONE) begin
                            case (i_prog_byte)
                                btm_pkg::CH_NUL: begin
                                    lzero = 1'b1;
                                end
                                btm_pkg::CH_OPEN: begin
                                    if (ldepth >= SDW'(MAX_PAIRS)) begin
                                        lerr = btm_pkg::ERR_NEST_OVF;
                                    end else begin
                                        stk_we    = 1'b1;
                                        stk_waddr = ldepth[SAW-1:0];
                                        stk_wdata = lpos[PAW-1:0];
                                        ldepth    = ldepth + SDW'(1);
                                    end
                                end
                                btm_pkg::CH_CLOSE: begin
                                    if (lpairs >= SDW'(MAX_PAIRS)) begin
                                        lerr = btm_pkg::ERR_PAIR_OVF;
                                    end else if (ldepth == '0) begin
                                        lerr = btm_pkg::ERR_STRAY;
                                    end else begin
                                        stk_re     = 1'b1;
                                        stk_raddr  = ldec[SAW-1:0];
                                        ldepth     = ldec;
                                        lpairs     = lpairs + SDW'(1);
                                        lpair      = 1'b1;
                                        n_pair_pos = lpos[PAW-1:0];
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    n_mode   = btm_pkg::MODE_LOADING;
                    n_strobe = 1'b1;
                    if (i_last_byte) begin
                        if (lerr == btm_pkg::ERR_NONE && ldepth != '0) begin
                            lerr = btm_pkg::ERR_OPEN_LEFT;
                        end
                        n_mode   = (lerr != btm_pkg::ERR_NONE) ? btm_pkg::MODE_ERROR
                                                               : btm_pkg::MODE_READY;
                        n_pc     = '0;
                        n_dp     = '0;
                        n_status = (lerr != btm_pkg::ERR_NONE) ? btm_pkg::ST_ERROR
                                                               : btm_pkg::ST_OK;
                        n_code   = lerr;
                    end
                    n_err       = lerr;
                    n_depth     = ldepth;
                    n_pairs     = lpairs;
                    n_zero_seen = lzero;
                    n_last      = i_last_byte;
                    n_clr       = '0;
                    if (lpair) begin
                        n_state = S_PAIR_A;
                    end else if (i_last_byte) begin
                        n_state = S_CLEAR;
                    end
                end else if (start) begin
                    case (r_mode)
                        btm_pkg::MODE_LOADING: begin
                            n_strobe = 1'b1;
                        end
                        btm_pkg::MODE_ENDED: begin
                            n_strobe = 1'b1;
                            n_status = btm_pkg::ST_ENDED;
                        end
                        btm_pkg::MODE_ERROR: begin
                            n_strobe = 1'b1;
                            n_status = btm_pkg::ST_ERROR;
                            n_code   = r_err;
                        end
                        default: begin
                            if (r_pc >= r_load_pos || r_pc >= PCW'(PROGRAM_DEPTH)) begin
                                n_mode   = btm_pkg::MODE_ENDED;
                                n_strobe = 1'b1;
                                n_status = btm_pkg::ST_ENDED;
                            end else begin
                                prog_re   = 1'b1;
                                jmp_re    = 1'b1;
                                dat_re    = 1'b1;
                                n_in_char = i_in_char;
                                n_in_eof  = i_in_eof;
                                n_state   = S_EXEC;
                            end
                        end
                    endcase
                end
            end

            S_EXEC: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (prog_rdata == btm_pkg::CH_NUL) begin
                    n_mode   = btm_pkg::MODE_ENDED;
                    n_status = btm_pkg::ST_ENDED;
                end else begin
                    n_pc = r_pc + PCW'(1);
                    case (prog_rdata)
                        btm_pkg::CH_LEFT: begin
                            if (r_dp == '0) begin
                                n_err    = btm_pkg::ERR_PTR_UNDER;
                                n_mode   = btm_pkg::MODE_ERROR;
                                n_status = btm_pkg::ST_ERROR;
                                n_code   = btm_pkg::ERR_PTR_UNDER;
                            end else begin
                                n_dp = r_dp - DAW'(1);
                            end
                        end
                        btm_pkg::CH_RIGHT: begin
                            if (r_dp == DAW'(DATA_DEPTH - 1)) begin
                                n_err    = btm_pkg::ERR_PTR_OVER;
                                n_mode   = btm_pkg::MODE_ERROR;
                                n_status = btm_pkg::ST_ERROR;
                                n_code   = btm_pkg::ERR_PTR_OVER;
                            end else begin
                                n_dp = r_dp + DAW'(1);
                            end
                        end
                        btm_pkg::CH_PLUS: begin
                            dat_we    = 1'b1;
                            dat_wdata = dat_rdata + 8'd1;
                        end
                        btm_pkg::CH_MINUS: begin
                            dat_we    = 1'b1;
                            dat_wdata = dat_rdata - 8'd1;
                        end
                        btm_pkg::CH_COMMA: begin
                            dat_we     = 1'b1;
                            dat_wdata  = r_in_eof ? 8'h00 : r_in_char;
                            n_in_taken = !r_in_eof;
                        end
                        btm_pkg::CH_DOT: begin
                            n_out_valid = 1'b1;
                            n_out_char  = dat_rdata;
                        end
                        btm_pkg::CH_OPEN: begin
                            if (dat_rdata == 8'h00) begin
                                n_pc = PCW'(jmp_rdata) + PCW'(1);
                            end
                        end
                        btm_pkg::CH_CLOSE: begin
                            if (dat_rdata != 8'h00) begin
                                n_pc = PCW'(jmp_rdata);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // close position points back at its open
            S_PAIR_A: begin
                jmp_we    = 1'b1;
                jmp_waddr = r_pair_pos;
                jmp_wdata = stk_rdata;
                n_state   = S_PAIR_B;
            end

            // open position points forward at its close; stack read data still held
            S_PAIR_B: begin
                jmp_we    = 1'b1;
                jmp_waddr = stk_rdata;
                jmp_wdata = r_pair_pos;
                n_clr     = '0;
                n_state   = r_last ? S_CLEAR : S_IDLE;
            end

            S_CLEAR: begin
                dat_we    = 1'b1;
                dat_waddr = r_clr;
                dat_wdata = 8'h00;
                if (r_clr == DAW'(DATA_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + DAW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= btm_pkg::MODE_READY;
            r_err       <= btm_pkg::ERR_NONE;
            r_pc        <= '0;
            r_dp        <= '0;
            r_load_pos  <= '0;
            r_depth     <= '0;
            r_pairs     <= '0;
            r_zero_seen <= 1'b0;
            r_last      <= 1'b0;
            r_clr       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_err       <= n_err;
            r_pc        <= n_pc;
            r_dp        <= n_dp;
            r_load_pos  <= n_load_pos;
            r_depth     <= n_depth;
            r_pairs     <= n_pairs;
            r_zero_seen <= n_zero_seen;
            r_last      <= n_last;
            r_clr       <= n_clr;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair_pos  <= n_pair_pos;
        r_in_char   <= n_in_char;
        r_in_eof    <= n_in_eof;
        r_out_valid <= n_out_valid;
        r_out_char  <= n_out_char;
        r_in_taken  <= n_in_taken;
        r_status    <= n_status;
        r_code      <= n_code;
    end

    assign o_result_strobe = r_strobe;
    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_in_taken      = r_in_taken;
    assign o_run_status    = r_status;
    assign o_error_code    = r_code;
    assign o_next_pc       = r_pc;

    btm_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (prog_wdata),
        .i_re    (prog_re),
        .i_raddr (prog_raddr),
        .o_rdata (prog_rdata)
    );

    btm_ram #(.WIDTH(PAW), .DEPTH(PROGRAM_DEPTH)) u_jump_ram (
        .i_clk   (i_clk),
        .i_we    (jmp_we),
        .i_waddr (jmp_waddr),
        .i_wdata (jmp_wdata),
        .i_re    (jmp_re),
        .i_raddr (jmp_raddr),
        .o_rdata (jmp_rdata)
    );

    btm_ram #(.WIDTH(PAW), .DEPTH(MAX_PAIRS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    btm_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_re    (dat_re),
        .i_raddr (dat_raddr),
        .o_rdata (dat_rdata)
    );

    // a result only follows an accepted beat or the execute cycle
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> ($past(accept) || $past(r_state == S_EXEC)))
        else $error("result strobe without a finishing item");

    a_stack_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth <= SDW'(MAX_PAIRS)) && (r_pairs <= SDW'(MAX_PAIRS)))
        else $error("bracket stack or pair count past limit");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_IDLE))
        else $error("execute cycle did not return to idle");

    a_pair_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR_A) |=> (r_state == S_PAIR_B))
        else $error("match table pair write split");

    a_error_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == btm_pkg::MODE_ERROR) |-> (r_err != btm_pkg::ERR_NONE))
        else $error("error stop with empty error latch");

endmodule
